>>> sv/kcx_pkg.sv
`timescale 1ns / 1ps

package kcx_pkg;

    // defaults for the top level parameters
    localparam int LIST_DEPTH_DEF  = 16;
    localparam int ID_BITS_DEF     = 64;
    localparam int HANDLE_BITS_DEF = 16;

    // fixed field widths on the stream ports
    localparam int ID_W     = 64;
    localparam int HANDLE_W = 16;
    localparam int SLOT_W   = 4;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 88;

    // func codes
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

endpackage

>>> sv/k_closest_xor_list.sv
`timescale 1ns / 1ps

// Sorted list of the LIST_DEPTH nodes closest (by XOR distance) to own_id.
// Channels: s-side items carry func in tuser (0 add, 1 read) and the node in
// tdata; m-side items carry one result each, tlast marks the final one of an
// input item. The user must write own_id on the cfg channel only while the
// block is idle; the block itself does not enforce this. Add: one slot of the
// list RAM is visited per cycle, inserting the newcomer and rippling the
// displaced entries down one place in the same pass. The walk visits slots 0
// to N for a list of N entries that is not full, every slot of a full list.
// Read: one result per cycle while the receiver keeps taking them; an empty
// list gives one invalid result. tready on the s-side is high only while no
// item is in progress; the result register lets a new item be accepted while
// the last result still waits. A stalled receiver holds a read walk in place.
// Reset clears the entry count, own_id and the output valid flag; list RAM
// contents are not cleared, only slots below the count are ever used.
module k_closest_xor_list #(
    parameter int LIST_DEPTH  = kcx_pkg::LIST_DEPTH_DEF,
    parameter int ID_BITS     = kcx_pkg::ID_BITS_DEF,
    parameter int HANDLE_BITS = kcx_pkg::HANDLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // cfg
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kcx_pkg::ID_W-1:0]        i_cfg_data,    // own_id
    // s-side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [kcx_pkg::IN_DATA_W-1:0]   i_s_tdata,     // node_id, node_handle
    input  logic                            i_s_tuser,     // func
    // m-side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // accepted, slot, entry_valid, entry_handle, entry_distance, zero pad
    output logic [kcx_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast      // last
);

    import kcx_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int EW = ID_BITS + HANDLE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_RES,
        S_RD
    } t_state;

    t_state r_state, n_state;

    logic [ID_BITS-1:0]     r_own, n_own;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_pos, n_pos;
    logic                   r_ins, n_ins;
    logic                   r_acc, n_acc;
    logic [ID_BITS-1:0]     r_dist, n_dist;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic [EW-1:0]          r_carry, n_carry;

    logic                   r_ovalid, n_ovalid;
    logic                   r_o_acc, n_o_acc;
    logic [SLOT_W-1:0]      r_o_slot, n_o_slot;
    logic                   r_o_ev, n_o_ev;
    logic [HANDLE_W-1:0]    r_o_handle, n_o_handle;
    logic [ID_W-1:0]        r_o_dist, n_o_dist;
    logic                   r_o_last, n_o_last;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [EW-1:0]          ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [EW-1:0]          ram_rdata;

    logic [ID_BITS-1:0]     rd_dist;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [CW-1:0]          idx_inc;
    logic                   out_free;
    logic                   is_tail;
    logic                   ins_here;
    logic [ID_W-1:0]        in_node_id;
    logic [HANDLE_W-1:0]    in_node_handle;

    kcx_ram #(
        .WIDTH (EW),
        .DEPTH (LIST_DEPTH)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // RAM entry: distance in the low bits, handle above
    assign rd_dist   = ram_rdata[ID_BITS-1:0];
    assign rd_handle = ram_rdata[EW-1:ID_BITS];

    assign in_node_id     = i_s_tdata[ID_W-1:0];
    assign in_node_handle = i_s_tdata[ID_W +: HANDLE_W];

    assign idx_inc  = r_idx + 1'b1;
    assign out_free = !r_ovalid || i_m_tready;
    assign is_tail  = (r_idx == r_count);
    // newcomer goes ahead of ties; an empty slot past the end always takes it
    assign ins_here = !r_ins && (is_tail || (r_dist <= rd_dist));

    always_comb begin
        n_state    = r_state;
        n_own      = r_own;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_ins      = r_ins;
        n_acc      = r_acc;
        n_dist     = r_dist;
        n_handle   = r_handle;
        n_carry    = r_carry;
        n_ovalid   = r_ovalid;
        n_o_acc    = r_o_acc;
        n_o_slot   = r_o_slot;
        n_o_ev     = r_o_ev;
        n_o_handle = r_o_handle;
        n_o_dist   = r_o_dist;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;
        ram_waddr  = r_idx[AW-1:0];
        ram_wdata  = r_carry;
        ram_re     = 1'b0;
        ram_raddr  = idx_inc[AW-1:0];

        if (i_cfg_valid) begin
            n_own = ID_BITS'(i_cfg_data);
        end

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_idx    = '0;
                    n_pos    = '0;
                    n_ins    = 1'b0;
                    n_acc    = 1'b0;
                    n_dist   = r_own ^ ID_BITS'(in_node_id);
                    n_handle = HANDLE_BITS'(in_node_handle);
                    if (i_s_tuser == FUNC_ADD) begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_state   = S_ADD;
                    end else if (r_count == '0) begin
                        n_state = S_RES;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_state   = S_RD;
                    end
                end
            end
            S_ADD: begin
                // one slot per cycle: write newcomer or carried entry, carry the old one
                if (ins_here || r_ins) begin
                    ram_we    = 1'b1;
                    ram_wdata = ins_here ? {r_handle, r_dist} : r_carry;
                end
                n_carry = ram_rdata;
                ram_re  = 1'b1;
                if (ins_here) begin
                    n_ins = 1'b1;
                    n_pos = r_idx;
                end
                if (is_tail || (r_idx == CW'(LIST_DEPTH - 1))) begin
                    // end of the walk; on a full list the carried last entry falls off
                    n_acc = r_ins || ins_here;
                    if (is_tail) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_RES;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_RES: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_acc    = r_acc;
                    n_o_slot   = SLOT_W'(r_pos);
                    n_o_ev     = 1'b0;
                    n_o_handle = '0;
                    n_o_dist   = '0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_RD: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_acc    = 1'b0;
                    n_o_slot   = SLOT_W'(r_idx);
                    n_o_ev     = 1'b1;
                    n_o_handle = HANDLE_W'(rd_handle);
                    n_o_dist   = ID_W'(rd_dist);
                    n_o_last   = (idx_inc == r_count);
                    ram_re     = 1'b1;
                    n_idx      = idx_inc;
                    if (idx_inc == r_count) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_own    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_own    <= n_own;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_ins      <= n_ins;
        r_acc      <= n_acc;
        r_dist     <= n_dist;
        r_handle   <= n_handle;
        r_carry    <= n_carry;
        r_o_acc    <= n_o_acc;
        r_o_slot   <= n_o_slot;
        r_o_ev     <= n_o_ev;
        r_o_handle <= n_o_handle;
        r_o_dist   <= n_o_dist;
        r_o_last   <= n_o_last;
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tlast   = r_o_last;
    assign o_m_tdata   = {2'b00, r_o_dist, r_o_handle, r_o_ev, r_o_slot, r_o_acc};

endmodule

>>> sv/kcx_ram.sv
`timescale 1ns / 1ps

module kcx_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import kcx_pkg::*;

    localparam int DEPTH        = LIST_DEPTH_DEF;
    localparam int DRAIN_CYCLES = LIST_DEPTH_DEF + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 50;

    typedef struct packed {
        logic                accepted;
        logic [SLOT_W-1:0]   slot;
        logic                entry_valid;
        logic [HANDLE_W-1:0] entry_handle;
        logic [ID_W-1:0]     entry_distance;
        logic                last;
    } t_list_result;

    // Mirror of the closest-node list plus the queue of results it predicts.
    class xor_list_scoreboard;
        logic [ID_W-1:0]     own_id;
        logic [ID_W-1:0]     dist_store[DEPTH];
        logic [HANDLE_W-1:0] handle_store[DEPTH];
        int unsigned         entry_count;
        t_list_result        pending_results[$];
        int unsigned         errors;

        function new();
            own_id      = '0;
            entry_count = 0;
            errors      = 0;
        endfunction

        function void note_item(logic func, logic [ID_W-1:0] node_id,
                                logic [HANDLE_W-1:0] handle);
            logic [ID_W-1:0] new_dist;
            int unsigned     pos;
            int unsigned     i;
            t_list_result    r;
            r = '0;
            r.last = 1'b1;
            if (func == FUNC_ADD) begin
                new_dist = own_id ^ node_id;
                pos      = DEPTH;
                // newcomer goes ahead of equal distances
                for (i = 0; i < DEPTH && pos == DEPTH; i++)
                    if (i == entry_count || new_dist <= dist_store[i])
                        pos = i;
                if (pos < DEPTH) begin
                    if (entry_count < DEPTH)
                        entry_count++;
                    for (i = entry_count - 1; i > pos; i--) begin
                        dist_store[i]   = dist_store[i - 1];
                        handle_store[i] = handle_store[i - 1];
                    end
                    dist_store[pos]   = new_dist;
                    handle_store[pos] = handle;
                    r.accepted = 1'b1;
                    r.slot     = pos[SLOT_W-1:0];
                end
                pending_results.push_back(r);
            end else if (entry_count == 0) begin
                pending_results.push_back(r);
            end else begin
                for (i = 0; i < entry_count; i++) begin
                    r.slot           = i[SLOT_W-1:0];
                    r.entry_valid    = 1'b1;
                    r.entry_handle   = handle_store[i];
                    r.entry_distance = dist_store[i];
                    r.last           = (i + 1 == entry_count);
                    pending_results.push_back(r);
                end
            end
        endfunction

        function void compare_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic tlast);
            t_list_result want;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: tdata 0x%0h", data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("accepted", ID_W'(want.accepted), ID_W'(data[0]));
            compare_field("slot", ID_W'(want.slot), ID_W'(data[4:1]));
            compare_field("entry_valid", ID_W'(want.entry_valid), ID_W'(data[5]));
            compare_field("entry_handle", ID_W'(want.entry_handle), ID_W'(data[21:6]));
            compare_field("entry_distance", want.entry_distance, data[85:22]);
            compare_field("last", ID_W'(want.last), ID_W'(tlast));
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [ID_W-1:0]       cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = FUNC_ADD;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    int unsigned           cycles    = 0;

    xor_list_scoreboard sb = new();

    k_closest_xor_list dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // valid stays high after acceptance; callers lower it when a gap follows
    task automatic offer_item(input logic func, input logic [ID_W-1:0] node_id,
                              input logic [HANDLE_W-1:0] handle);
        s_tvalid <= 1'b1;
        s_tdata  <= {handle, node_id};
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(func, node_id, handle);
    endtask

    task automatic add_at_distance(input logic [ID_W-1:0] distance,
                                   input logic [HANDLE_W-1:0] handle);
        offer_item(FUNC_ADD, sb.own_id ^ distance, handle);
    endtask

    task automatic pause_sender(input int unsigned n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_own_id(input logic [ID_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.own_id = value;
    endtask

    // mostly short distances so a full list still takes insertions; some ties
    function automatic logic [ID_W-1:0] pick_distance();
        logic [ID_W-1:0] r;
        int              k;
        r = {$urandom, $urandom};
        k = $urandom_range(0, 99);
        if (k < 15 && sb.entry_count != 0)
            return sb.dist_store[$urandom_range(0, sb.entry_count - 1)];
        if (k < 20)
            return '0;
        if (k < 25)
            return '1;
        if (k < 35)
            return r;
        return r >> $urandom_range(1, ID_W - 1);
    endfunction

    // result side: changing stall patterns, one long hold-off
    initial begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned seen;
        bit          held;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        seen      = 0;
        held      = 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tlast);
                seen++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held && seen >= 40) begin
                held      = 1'b1;
                hold_left = 300;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [ID_W-1:0] phase_ids[5];
        int unsigned     ph;
        int unsigned     n;
        int unsigned     burst_left;
        int unsigned     gap;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty read, extremes, ties, filling, overflow, rejection
        set_own_id('1);
        offer_item(FUNC_READ, '0, '0);
        add_at_distance('1, 16'hFFFF);
        add_at_distance('0, 16'h0000);
        add_at_distance('0, 16'h0001);
        add_at_distance(64'd5, 16'hA5A5);
        repeat (DEPTH - 4)
            add_at_distance({$urandom, $urandom} >> 8, HANDLE_W'($urandom));
        // full list: a small distance pushes the farthest entry out
        add_at_distance(64'd1, 16'h5A5A);
        // full list, everything stored is closer
        add_at_distance('1, 16'h1234);
        offer_item(FUNC_READ, '1, '1);

        phase_ids[0] = '0;
        phase_ids[1] = {$urandom, $urandom};
        phase_ids[2] = '1;
        phase_ids[3] = {$urandom, $urandom};
        phase_ids[4] = 64'h8000_0000_0000_0001;
        burst_left   = 0;
        for (ph = 0; ph < 5; ph++) begin
            set_own_id(phase_ids[ph]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 25)
                    offer_item(FUNC_READ, {$urandom, $urandom}, HANDLE_W'($urandom));
                else
                    add_at_distance(pick_distance(), HANDLE_W'($urandom));
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap        = $urandom_range(0, 8);
                    if (gap != 0)
                        pause_sender(gap);
                end else begin
                    burst_left--;
                end
            end
        end

        wait_drained();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
